### rtl/rfma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring frame marker aligner package
// Shared constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package rfma_pkg;

  // Default bytes per bank.
  localparam int BUFFER_DEPTH_DEF = 256;

  // Configuration port widths.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 9;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LEN    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MARKER_BYTE0 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MARKER_BYTE1 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MARKER_BYTE2 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MARKER_BYTE3 = 3'd4;

  // Register reset values.
  localparam logic [8:0] FRAME_LEN_RST    = 9'd150;
  localparam logic [7:0] MARKER_BYTE0_RST = 8'h23;  // '#'
  localparam logic [7:0] MARKER_BYTE1_RST = 8'h73;  // 's'
  localparam logic [7:0] MARKER_BYTE2_RST = 8'h74;  // 't'
  localparam logic [7:0] MARKER_BYTE3_RST = 8'h61;  // 'a'

  // Shortest frame: the marker is four bytes long.
  localparam int MIN_FRAME_LEN = 4;
  localparam int MARKER_LEN    = 4;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_OUT,
    ST_SEARCH
  } state_t;

endpackage

### rtl/rfma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring frame marker aligner bank memory
// Simple dual-port byte memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rfma_ram #(
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ring_frame_marker_aligner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring frame marker aligner
// Loads received bytes into one of two banks, searches each completed frame
// for a four-byte start marker and releases the previous frame rotated so
// that the marker comes first, one byte per received byte.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | tdata (low bit up)             | tlast     | tuser
// ---------+-----------+--------------------------------+-----------+-------------
// s_axis   | in        | rx_byte[7:0]                   | -         | -
// m_axis   | out       | aligned_byte, aligned_index    | frame_end | marker_found
// cfg      | in        | write port: cfg_we, cfg_addr, cfg_data
//
// A beat taken before any frame has completed stores its byte. A beat
// that releases a byte first reduces the ring offset with a restoring
// compare-subtract unit, one quotient bit a cycle, then reads the other bank.
// The beat that completes a frame adds a marker scan, one bank read a cycle
// through a four-byte window. s_axis is held off until the sequencer is idle
// again; a stalled m_axis holds the sequencer on the output step. rst clears
// the configuration, sequencer, frame, scan and output valid state; the banks
// need no clearing.
// ----------------------------------------------------------------------------
module ring_frame_marker_aligner #(
  parameter int BUFFER_DEPTH = rfma_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // rx_byte[7:0]
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // aligned_byte, aligned_index
  output logic                            m_axis_tlast,   // frame_end
  output logic                            m_axis_tuser,   // marker_found
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [rfma_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rfma_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + rfma_pkg::MARKER_LEN);
  localparam int CMP_W = ((CNT_W > rfma_pkg::CFG_DATA_W) ? CNT_W : rfma_pkg::CFG_DATA_W) + 1;
  localparam int MW    = CNT_W + IDX_W;
  localparam int KW    = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int AW    = IDX_W + 1;

  // Configuration registers.
  logic [8:0] frame_len;
  logic [7:0] marker_byte0;
  logic [7:0] marker_byte1;
  logic [7:0] marker_byte2;
  logic [7:0] marker_byte3;

  // Frame state.
  rfma_pkg::state_t state, state_next;
  logic [IDX_W-1:0] write_position;
  logic             load_bank;
  logic [IDX_W-1:0] rotation_amount;
  logic             found_flag;
  logic             frame_ready;

  // Per-beat working registers.
  logic [IDX_W-1:0] cur_pos;
  logic             cur_last;
  logic             cur_bank;
  logic [IDX_W:0]   rem;
  logic [KW-1:0]    kbit;

  // Marker scan registers.
  logic [CNT_W-1:0] scan_issued;
  logic [CNT_W-1:0] scan_count;
  logic             scan_pend;
  logic [7:0]       win0, win1, win2, win3;

  // Output register.
  logic             out_valid;
  logic [7:0]       out_byte;
  logic [7:0]       out_index;
  logic             out_last;
  logic             out_found;

  // Memory ports.
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       mem_rdata;

  // Control strobes.
  logic             in_accept;
  logic             out_load;
  logic             out_free;
  logic             scan_issue;
  logic             scan_hit;
  logic             scan_miss;

  // Derived values.
  logic [CMP_W-1:0] fl_wide;
  logic [CNT_W-1:0] eff_len;
  logic             is_last;
  logic [MW-1:0]    div_shifted;
  logic             div_take;
  logic [CNT_W-1:0] scan_addr_full;
  logic [IDX_W+7:0] pos_pad;

  // --------------------------------------------------------------------------
  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len    <= rfma_pkg::FRAME_LEN_RST;
      marker_byte0 <= rfma_pkg::MARKER_BYTE0_RST;
      marker_byte1 <= rfma_pkg::MARKER_BYTE1_RST;
      marker_byte2 <= rfma_pkg::MARKER_BYTE2_RST;
      marker_byte3 <= rfma_pkg::MARKER_BYTE3_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rfma_pkg::REG_FRAME_LEN:    frame_len    <= cfg_data;
        rfma_pkg::REG_MARKER_BYTE0: marker_byte0 <= cfg_data[7:0];
        rfma_pkg::REG_MARKER_BYTE1: marker_byte1 <= cfg_data[7:0];
        rfma_pkg::REG_MARKER_BYTE2: marker_byte2 <= cfg_data[7:0];
        rfma_pkg::REG_MARKER_BYTE3: marker_byte3 <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Frame length clamped to the legal range.
  always_comb begin
    fl_wide = CMP_W'(frame_len);
    if (fl_wide < CMP_W'(rfma_pkg::MIN_FRAME_LEN)) begin
      eff_len = CNT_W'(rfma_pkg::MIN_FRAME_LEN);
    end else if (fl_wide > CMP_W'(BUFFER_DEPTH)) begin
      eff_len = CNT_W'(BUFFER_DEPTH);
    end else begin
      eff_len = fl_wide[CNT_W-1:0];
    end
  end

  assign is_last = (CNT_W'(write_position) + CNT_W'(1)) >= eff_len;

  // Compare-subtract unit for the ring offset reduction, reused for every quotient bit.
  assign div_shifted = MW'(eff_len) << kbit;
  assign div_take    = MW'(rem) >= div_shifted;

  // Scan address wraps once past the end of the ring.
  assign scan_addr_full = (scan_issued >= eff_len) ? (scan_issued - eff_len) : scan_issued;

  // Window compare against the marker.
  assign scan_hit  = (scan_count >= CNT_W'(rfma_pkg::MARKER_LEN)) &&
                     (win0 == marker_byte0) && (win1 == marker_byte1) &&
                     (win2 == marker_byte2) && (win3 == marker_byte3);
  assign scan_miss = !scan_hit && (scan_count == eff_len + CNT_W'(3));
  assign scan_issue = (scan_issued < eff_len + CNT_W'(3));

  assign out_free  = !out_valid || m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Sequencer: next state and strobes.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = {~cur_bank, rem[IDX_W-1:0]};
    unique case (state)
      rfma_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (frame_ready) begin
            state_next = rfma_pkg::ST_MOD;
          end else if (is_last) begin
            state_next = rfma_pkg::ST_SEARCH;
          end
        end
      end
      rfma_pkg::ST_MOD: begin
        if (kbit == '0) begin
          state_next = rfma_pkg::ST_READ;
        end
      end
      rfma_pkg::ST_READ: begin
        mem_re     = 1'b1;
        state_next = rfma_pkg::ST_OUT;
      end
      rfma_pkg::ST_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = cur_last ? rfma_pkg::ST_SEARCH : rfma_pkg::ST_IDLE;
        end
      end
      rfma_pkg::ST_SEARCH: begin
        mem_re    = scan_issue;
        mem_raddr = {cur_bank, scan_addr_full[IDX_W-1:0]};
        if (scan_hit || scan_miss) begin
          state_next = rfma_pkg::ST_IDLE;
        end
      end
      default: state_next = rfma_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Beat intake: store the byte and advance the write position.
  assign mem_we    = in_accept;
  assign mem_waddr = {load_bank, write_position};

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      load_bank      <= 1'b0;
      frame_ready    <= 1'b0;
    end else if (in_accept) begin
      if (is_last) begin
        write_position <= '0;
        load_bank      <= ~load_bank;
        frame_ready    <= 1'b1;
      end else begin
        write_position <= write_position + IDX_W'(1);
      end
    end
  end

  // Working copy of the beat; the offset is reduced one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_pos  <= write_position;
      cur_last <= is_last;
      cur_bank <= load_bank;
      rem      <= (IDX_W + 1)'(write_position) + (IDX_W + 1)'(rotation_amount);
      kbit     <= KW'(IDX_W - 1);
    end else if (state == rfma_pkg::ST_MOD) begin
      if (div_take) begin
        rem <= rem - div_shifted[IDX_W:0];
      end
      kbit <= kbit - KW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Marker scan: one bank read a cycle into a four-byte sliding window.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_issued     <= '0;
      scan_count      <= '0;
      scan_pend       <= 1'b0;
      rotation_amount <= '0;
      found_flag      <= 1'b0;
    end else if (state == rfma_pkg::ST_SEARCH) begin
      if (scan_issue) begin
        scan_issued <= scan_issued + CNT_W'(1);
      end
      scan_pend <= scan_issue;
      if (scan_pend) begin
        scan_count <= scan_count + CNT_W'(1);
      end
      if (scan_hit) begin
        rotation_amount <= IDX_W'(scan_count - CNT_W'(rfma_pkg::MARKER_LEN));
        found_flag      <= 1'b1;
      end else if (scan_miss) begin
        rotation_amount <= '0;
        found_flag      <= 1'b0;
      end
    end else begin
      scan_issued <= '0;
      scan_count  <= '0;
      scan_pend   <= 1'b0;
    end
  end

  // Window shift, oldest byte in win0.
  always_ff @(posedge clk) begin
    if (state == rfma_pkg::ST_SEARCH && scan_pend) begin
      win0 <= win1;
      win1 <= win2;
      win2 <= win3;
      win3 <= mem_rdata;
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  assign pos_pad = {8'b0, cur_pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte  <= mem_rdata;
      out_index <= pos_pad[7:0];
      out_last  <= cur_last;
      out_found <= found_flag;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_index, out_byte};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_found;

  // --------------------------------------------------------------------------
  // Bank memory.
  rfma_ram #(
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (s_axis_tdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

`ifndef SYNTHESIS
  // The ring offset is fully reduced before the other bank is read.
  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    state == rfma_pkg::ST_READ |-> CNT_W'(rem) < eff_len)
    else $error("ring offset not reduced below frame length");

  // The scan window never takes more bytes than were read.
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    state == rfma_pkg::ST_SEARCH |-> scan_count <= scan_issued)
    else $error("scan window ahead of bank reads");

  // Once a frame has completed, frames keep being released until reset.
  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    frame_ready |=> frame_ready)
    else $error("completed frame flag dropped");

  // Every released byte comes from the output step of the sequencer.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == rfma_pkg::ST_OUT)
    else $error("output beat raised outside the output step");
`endif

endmodule

### tb/tb_ring_frame_marker_aligner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring frame marker aligner testbench
// Streams received bytes through the aligner and checks every released beat
// against an in-bench predictor of the two-bank frame ring and its marker
// search. Covers reset marker values, clamped and changed frame lengths,
// wrapped, missing and broken markers, random idling on both streams and a
// long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_ring_frame_marker_aligner;

  localparam int DEPTH        = rfma_pkg::BUFFER_DEPTH_DEF;
  localparam int ITEM_TARGET  = 1650;
  localparam int CALM_TAIL    = 150;   // items at the end sent without idling
  localparam int SETTLE       = 300;   // covers one scan of the longest frame
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] index;
    logic       last;
    logic       found;
  } aligned_beat_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [15:0]                     m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            m_axis_tuser;
  logic                            cfg_we = 1'b0;
  logic [rfma_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [rfma_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ring_frame_marker_aligner dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // Mirror of the aligner: registers, both banks and the control state.
  logic [8:0]    frame_len_q = rfma_pkg::FRAME_LEN_RST;
  logic [7:0]    marker_q [rfma_pkg::MARKER_LEN] = '{rfma_pkg::MARKER_BYTE0_RST,
                                                     rfma_pkg::MARKER_BYTE1_RST,
                                                     rfma_pkg::MARKER_BYTE2_RST,
                                                     rfma_pkg::MARKER_BYTE3_RST};
  logic [7:0]    bank_mem [2*DEPTH];
  int            load_pos = 0;
  bit            load_sel = 1'b0;
  int            rotation_q = 0;
  bit            found_q = 1'b0;
  bit            frame_done_q = 1'b0;

  aligned_beat_t aligned_q [$];
  int            mismatches = 0;
  int            items_sent = 0;
  bit            idle_en = 1'b1;
  bit            hold_req = 1'b0;
  int            quiet_cycles = 0;

  function automatic int ring_len(input logic [8:0] len_reg);
    if (len_reg < rfma_pkg::MIN_FRAME_LEN) return rfma_pkg::MIN_FRAME_LEN;
    if (len_reg > DEPTH) return DEPTH;
    return int'(len_reg);
  endfunction

  // First ring position where the four marker bytes follow one another.
  function automatic void find_marker(input bit sel, input int len);
    int  base;
    bit  hit;
    base       = sel * DEPTH;
    rotation_q = 0;
    found_q    = 1'b0;
    for (int i = 0; i < len; i++) begin
      hit = 1'b1;
      for (int k = 0; k < rfma_pkg::MARKER_LEN; k++)
        if (bank_mem[base + (i + k) % len] != marker_q[k]) hit = 1'b0;
      if (hit) begin
        rotation_q = i;
        found_q    = 1'b1;
        return;
      end
    end
  endfunction

  // Store one received byte and queue the rotated byte it releases, if any.
  function automatic void load_rx_byte(input logic [7:0] rx);
    int            len;
    int            pos;
    bit            last;
    aligned_beat_t beat;
    len  = ring_len(frame_len_q);
    pos  = load_pos % DEPTH;
    last = (pos + 1 >= len);
    bank_mem[load_sel * DEPTH + pos] = rx;
    if (frame_done_q) begin
      beat.data  = bank_mem[(!load_sel) * DEPTH + (pos + rotation_q) % len];
      beat.index = pos[7:0];
      beat.last  = last;
      beat.found = found_q;
      aligned_q.push_back(beat);
    end
    if (last) begin
      find_marker(load_sel, len);
      frame_done_q = 1'b1;
      load_sel     = !load_sel;
      load_pos     = 0;
    end else begin
      load_pos = pos + 1;
    end
  endfunction

  function automatic void report_mismatch(input string what);
    if (mismatches < 10) $display("%0t: %s", $realtime, what);
    mismatches++;
  endfunction

  // Predict on every accepted input beat, then check every accepted output
  // beat, both in one process so the same-edge order is fixed.
  always @(posedge clk) begin
    aligned_beat_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) load_rx_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (aligned_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat byte %02h index %0d last %0b found %0b",
                                    m_axis_tdata[7:0], m_axis_tdata[15:8],
                                    m_axis_tlast, m_axis_tuser));
        end else begin
          want = aligned_q.pop_front();
          if (m_axis_tdata[7:0] !== want.data || m_axis_tdata[15:8] !== want.index ||
              m_axis_tlast !== want.last || m_axis_tuser !== want.found)
            report_mismatch($sformatf({"beat mismatch: expected byte %02h index %0d ",
                                       "last %0b found %0b, got byte %02h index %0d ",
                                       "last %0b found %0b"},
                                      want.data, want.index, want.last, want.found,
                                      m_axis_tdata[7:0], m_axis_tdata[15:8],
                                      m_axis_tlast, m_axis_tuser));
        end
      end
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    int stall_left;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req      = 1'b0;
      stall_left    = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left    = $urandom_range(1, 14) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: ends the run after a long stretch with no beat on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one byte, after an optional idle burst, and wait for its handshake.
  task automatic send_byte(input logic [7:0] rx);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Stop offering and let the aligner finish every beat and any scan. The
  // predictor sees the last accepted byte before the queue is checked.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (aligned_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [rfma_pkg::CFG_ADDR_W-1:0] addr,
                           input int unsigned value);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value[rfma_pkg::CFG_DATA_W-1:0];
    case (addr)
      rfma_pkg::REG_FRAME_LEN:    frame_len_q = value[8:0];
      rfma_pkg::REG_MARKER_BYTE0: marker_q[0] = value[7:0];
      rfma_pkg::REG_MARKER_BYTE1: marker_q[1] = value[7:0];
      rfma_pkg::REG_MARKER_BYTE2: marker_q[2] = value[7:0];
      rfma_pkg::REG_MARKER_BYTE3: marker_q[3] = value[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_markers(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
    cfg_write(rfma_pkg::REG_MARKER_BYTE0, 32'(b0));
    cfg_write(rfma_pkg::REG_MARKER_BYTE1, 32'(b1));
    cfg_write(rfma_pkg::REG_MARKER_BYTE2, 32'(b2));
    cfg_write(rfma_pkg::REG_MARKER_BYTE3, 32'(b3));
  endtask

  // One frame of len bytes, about half drawn from the marker bytes so that near
  // misses are common. A marker is placed at marker_at (wrapping around the
  // ring) unless it is negative; a broken marker has one byte flipped.
  task automatic send_frame(input int len, input int marker_at, input bit broken);
    logic [7:0] frame [];
    int         bad;
    frame = new[len];
    for (int i = 0; i < len; i++)
      frame[i] = $urandom_range(0, 1) ? marker_q[$urandom_range(0, 3)]
                                      : 8'($urandom_range(0, 255));
    if (marker_at >= 0) begin
      for (int k = 0; k < rfma_pkg::MARKER_LEN; k++)
        frame[(marker_at + k) % len] = marker_q[k];
      if (broken) begin
        bad = $urandom_range(0, 3);
        frame[(marker_at + bad) % len] = marker_q[bad] ^ 8'h01;
      end
    end
    for (int i = 0; i < len; i++) send_byte(frame[i]);
  endtask

  // Two full-depth frames with the reset marker: the first returns nothing,
  // the second releases the first with every index up to the top.
  task automatic test_full_depth_frames();
    cfg_write(rfma_pkg::REG_FRAME_LEN, DEPTH);
    send_frame(DEPTH, DEPTH - 2, 1'b0);
    send_frame(DEPTH, 0, 1'b0);
  endtask

  task automatic test_short_frames();
    wait_idle();
    cfg_write(rfma_pkg::REG_FRAME_LEN, 0);          // clamps to the shortest frame
    set_markers(8'hFF, 8'h00, 8'hAA, 8'h55);
    // Marker at the start of the ring.
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'hAA); send_byte(8'h55);
    // Marker wrapping from the last position.
    send_byte(8'h00); send_byte(8'hAA); send_byte(8'h55); send_byte(8'hFF);
    // No marker: the frame passes unrotated.
    repeat (4) send_byte(8'h00);
    repeat (4) send_byte(8'h5A);
  endtask

  // The frame length is raised between frames, then lowered below the
  // current write position so that the next byte closes the frame.
  task automatic test_length_changes();
    logic [7:0] head [7] = '{8'h3C, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h3C, 8'h3C};
    wait_idle();
    cfg_write(rfma_pkg::REG_FRAME_LEN, 12);
    foreach (head[i]) send_byte(head[i]);
    wait_idle();
    cfg_write(rfma_pkg::REG_FRAME_LEN, 5);
    send_byte(8'h3C);
    repeat (5) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_output_hold_off();
    hold_req = 1'b1;
    repeat (20) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_frames();
    int         pick;
    int         len;
    int         frames;
    logic [7:0] a;
    logic [7:0] b;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - CALM_TAIL) idle_en = 1'b0;
      wait_idle();
      pick = $urandom_range(0, 19);
      case (pick)
        0:       cfg_write(rfma_pkg::REG_FRAME_LEN, $urandom_range(0, 3));
        1:       cfg_write(rfma_pkg::REG_FRAME_LEN, $urandom_range(257, 511));
        2, 3:    cfg_write(rfma_pkg::REG_FRAME_LEN, $urandom_range(100, 256));
        default: cfg_write(rfma_pkg::REG_FRAME_LEN, $urandom_range(4, 40));
      endcase
      a = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
        0:       set_markers(a, a, a, a);
        1:       set_markers(a, b, a, b);
        default: set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      len    = ring_len(frame_len_q);
      frames = (len > 100) ? 1 : $urandom_range(1, 4);
      repeat (frames) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_frame(len, $urandom_range(0, len - 1), 1'b0);
          6:                send_frame(len, 0, 1'b0);
          7:                send_frame(len, $urandom_range(0, len - 1), 1'b1);
          default:          send_frame(len, -1, 1'b0);
        endcase
      end
      // Sometimes leave a frame open so the next length change lands mid-frame.
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, len - 1)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    foreach (bank_mem[i]) bank_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_full_depth_frames();
    test_short_frames();
    test_length_changes();
    test_output_hold_off();
    test_random_frames();

    wait_idle();
    if (mismatches == 0 && aligned_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
